FILE: hdl/refcounted_page_allocator_core_macros.svh
// assertion macros for the page allocator modules, used by rpa_ctrl
// depends on nothing; each user supplies clk and rst_n in scope
`ifndef REFCOUNTED_PAGE_ALLOCATOR_CORE_MACROS_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_CORE_MACROS_SVH

// property holds at every clock edge outside reset
`define RPA_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define RPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/rpa_pkg.sv
// shared types, codes and default sizes for the page allocator
// no dependencies
package rpa_pkg;

    localparam int NUM_PAGES_DEF  = 32768;
    localparam int COUNT_BITS_DEF = 8;

    localparam int CMD_W    = 3;
    localparam int PAGE_W   = 15;
    localparam int REFC_W   = 8;
    localparam int STATUS_W = 3;

    localparam logic [CMD_W-1:0] CMD_ALLOC  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FREE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INC    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEC    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DONATE = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SAT   = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic load;    // input beat taken, launch memory reads
        logic commit;  // apply writes and load the result register
        logic clr;     // clearing pass step on the count memory
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;  // clearing pass is at its last entry
    } dp_status_t;

endpackage

FILE: hdl/rpa_datapath.sv
// count memory, free stack memory, stack pointer, config register and result register
// depends on rpa_pkg
module rpa_datapath #(
    parameter int NUM_PAGES  = rpa_pkg::NUM_PAGES_DEF,
    parameter int COUNT_BITS = rpa_pkg::COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rpa_pkg::ctrl_cmd_t            ctl,
    output rpa_pkg::dp_status_t           sts,
    input  logic                          cfg_valid,
    input  logic [rpa_pkg::PAGE_W-1:0]    cfg_data,
    input  logic [rpa_pkg::CMD_W-1:0]     cmd,
    input  logic [rpa_pkg::PAGE_W-1:0]    page_index,
    output logic [rpa_pkg::PAGE_W-1:0]    page_index_res,
    output logic [rpa_pkg::REFC_W-1:0]    ref_count,
    output logic [rpa_pkg::STATUS_W-1:0]  status,
    output logic                          returned_to_pool
);

    localparam int PW  = $clog2(NUM_PAGES);
    localparam int FCW = $clog2(NUM_PAGES + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CONE = COUNT_BITS'(1);

    logic [COUNT_BITS-1:0] cnt_mem [NUM_PAGES];
    logic [PW-1:0]         stk_mem [NUM_PAGES];

    logic [rpa_pkg::CMD_W-1:0]  cmd_reg;
    logic [rpa_pkg::PAGE_W-1:0] page_reg;
    logic [COUNT_BITS-1:0]      cnt_rd_reg;
    logic [PW-1:0]              top_rd_reg;
    logic [FCW-1:0]             free_count_reg, free_count_next;
    logic [rpa_pkg::PAGE_W-1:0] first_usable_reg;
    logic [PW-1:0]              clr_cnt_reg;

    logic [rpa_pkg::PAGE_W-1:0]   res_page_reg;
    logic [rpa_pkg::REFC_W-1:0]   res_cnt_reg;
    logic [rpa_pkg::STATUS_W-1:0] res_st_reg;
    logic                         res_ret_reg;

    logic [31:0]           in_pg32, pg32, top32, fc32, cnt32;
    logic [PW-1:0]         in_addr, pg_addr, pop_addr, top_pg;
    logic                  in_range, top_ok, below_first, room;
    logic [COUNT_BITS-1:0] cnt_dec, res_cnt;
    logic [rpa_pkg::PAGE_W-1:0]   res_page;
    logic [rpa_pkg::STATUS_W-1:0] res_st;
    logic                  res_ret;
    logic                  cnt_we, stk_we;
    logic [PW-1:0]         cnt_wa;
    logic [COUNT_BITS-1:0] cnt_wd;
    logic                  mem_cnt_we;
    logic [PW-1:0]         mem_cnt_wa;
    logic [COUNT_BITS-1:0] mem_cnt_wd;
    logic [FCW-1:0]        fc_dec;

    assign in_pg32  = 32'(page_index);
    assign in_addr  = in_pg32[PW-1:0];
    assign pg32     = 32'(page_reg);
    assign pg_addr  = pg32[PW-1:0];
    assign fc_dec   = free_count_reg - FCW'(1);
    assign pop_addr = fc_dec[PW-1:0];
    assign top32    = 32'(top_rd_reg);
    assign top_ok   = top32 < NUM_PAGES;
    assign top_pg   = top_ok ? top_rd_reg : '0;
    assign fc32     = 32'(free_count_reg);
    assign room     = fc32 < NUM_PAGES;
    assign in_range = pg32 < NUM_PAGES;
    assign below_first = page_reg < first_usable_reg;
    assign cnt_dec  = cnt_rd_reg - CONE;
    assign cnt32    = 32'(res_cnt);

    assign sts.clr_last = 32'(clr_cnt_reg) == (NUM_PAGES - 1);

    always_comb
    begin
        logic [31:0] tp;
        tp              = 32'(top_pg);
        res_page        = page_reg;
        res_cnt         = '0;
        res_st          = rpa_pkg::ST_OK;
        res_ret         = 1'b0;
        cnt_we          = 1'b0;
        cnt_wa          = pg_addr;
        cnt_wd          = '0;
        stk_we          = 1'b0;
        free_count_next = free_count_reg;
        if (cmd_reg == rpa_pkg::CMD_ALLOC)
        begin
            if (free_count_reg == '0)
            begin
                res_page = '0;
                res_st   = rpa_pkg::ST_EMPTY;
            end
            else
            begin
                free_count_next = fc_dec;
                res_page        = tp[rpa_pkg::PAGE_W-1:0];
                res_cnt         = CONE;
                cnt_we          = 1'b1;
                cnt_wa          = top_pg;
                cnt_wd          = CONE;
            end
        end
        else if (cmd_reg > rpa_pkg::CMD_DONATE)
        begin
            res_cnt = '0;
        end
        else if (!in_range)
        begin
            res_st = rpa_pkg::ST_RANGE;
        end
        else
        begin
            unique case (cmd_reg)
                rpa_pkg::CMD_FREE:
                begin
                    if (below_first)
                    begin
                        res_cnt = cnt_rd_reg;
                        res_st  = rpa_pkg::ST_RANGE;
                    end
                    else if (cnt_rd_reg == '0)
                    begin
                        res_st = rpa_pkg::ST_ZERO;
                    end
                    else
                    begin
                        res_cnt = cnt_dec;
                        cnt_we  = 1'b1;
                        cnt_wd  = cnt_dec;
                        if (cnt_dec == '0 && room)
                        begin
                            stk_we          = 1'b1;
                            res_ret         = 1'b1;
                            free_count_next = free_count_reg + FCW'(1);
                        end
                    end
                end
                rpa_pkg::CMD_INC:
                begin
                    if (cnt_rd_reg == CMAX)
                    begin
                        res_cnt = CMAX;
                        res_st  = rpa_pkg::ST_SAT;
                    end
                    else
                    begin
                        res_cnt = cnt_rd_reg + CONE;
                        cnt_we  = 1'b1;
                        cnt_wd  = cnt_rd_reg + CONE;
                    end
                end
                rpa_pkg::CMD_DEC:
                begin
                    if (cnt_rd_reg == '0)
                    begin
                        res_st = rpa_pkg::ST_ZERO;
                    end
                    else
                    begin
                        res_cnt = cnt_dec;
                        cnt_we  = 1'b1;
                        cnt_wd  = cnt_dec;
                    end
                end
                rpa_pkg::CMD_READ:
                begin
                    res_cnt = cnt_rd_reg;
                end
                rpa_pkg::CMD_DONATE:
                begin
                    if (below_first)
                    begin
                        res_cnt = cnt_rd_reg;
                        res_st  = rpa_pkg::ST_RANGE;
                    end
                    else
                    begin
                        // seeded to one then released, so it always lands at zero
                        res_cnt = '0;
                        cnt_we  = 1'b1;
                        cnt_wd  = '0;
                        if (room)
                        begin
                            stk_we          = 1'b1;
                            res_ret         = 1'b1;
                            free_count_next = free_count_reg + FCW'(1);
                        end
                    end
                end
                default:
                begin
                    res_cnt = '0;
                end
            endcase
        end
    end

    // clearing pass owns the count write port until it finishes
    always_comb
    begin
        if (ctl.clr)
        begin
            mem_cnt_we = 1'b1;
            mem_cnt_wa = clr_cnt_reg;
            mem_cnt_wd = '0;
        end
        else
        begin
            mem_cnt_we = ctl.commit && cnt_we;
            mem_cnt_wa = cnt_wa;
            mem_cnt_wd = cnt_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_cnt_we)
        begin
            cnt_mem[mem_cnt_wa] <= mem_cnt_wd;
        end
        if (ctl.load)
        begin
            cnt_rd_reg <= cnt_mem[in_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit && stk_we)
        begin
            stk_mem[free_count_reg[PW-1:0]] <= pg_addr;
        end
        if (ctl.load)
        begin
            top_rd_reg <= stk_mem[pop_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= cmd;
            page_reg <= page_index;
        end
        if (ctl.commit)
        begin
            res_page_reg <= res_page;
            res_cnt_reg  <= cnt32[rpa_pkg::REFC_W-1:0];
            res_st_reg   <= res_st;
            res_ret_reg  <= res_ret;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_count_reg   <= '0;
            first_usable_reg <= '0;
            clr_cnt_reg      <= '0;
        end
        else
        begin
            if (ctl.commit)
            begin
                free_count_reg <= free_count_next;
            end
            if (cfg_valid)
            begin
                first_usable_reg <= cfg_data;
            end
            if (ctl.clr)
            begin
                clr_cnt_reg <= clr_cnt_reg + PW'(1);
            end
        end
    end

    assign page_index_res   = res_page_reg;
    assign ref_count        = res_cnt_reg;
    assign status           = res_st_reg;
    assign returned_to_pool = res_ret_reg;

endmodule

FILE: hdl/rpa_ctrl.sv
// command sequencer: clearing pass, accept, execute, result register handshake
// depends on rpa_pkg and refcounted_page_allocator_core_macros.svh
`include "refcounted_page_allocator_core_macros.svh"

module rpa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rpa_pkg::ctrl_cmd_t   ctl,
    input  rpa_pkg::dp_status_t  sts
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    // result register can take a new beat if empty or draining this cycle
    assign slot_free  = !out_valid_reg || out_ready;
    assign in_ready   = state_reg == ST_IDLE;
    assign out_valid  = out_valid_reg;
    assign ctl.load   = in_valid && in_ready;
    assign ctl.commit = (state_reg == ST_EXEC) && slot_free;
    assign ctl.clr    = state_reg == ST_CLEAR;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (ctl.load)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (ctl.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `RPA_ASSERT_NEXT(a_load_to_exec, ctl.load, state_reg == ST_EXEC, "accepted beat did not enter execute")
    `RPA_ASSERT_NEXT(a_commit_valid, ctl.commit, out_valid_reg, "committed result not presented")
    `RPA_ASSERT_NEXT(a_stall_holds, (state_reg == ST_EXEC) && !slot_free, state_reg == ST_EXEC, "execute left while result register full")
    `RPA_ASSERT_NEXT(a_clear_runs, (state_reg == ST_CLEAR) && !sts.clr_last, state_reg == ST_CLEAR, "clearing pass ended early")
    `RPA_ASSERT_ALWAYS(a_no_load_clear, !(ctl.clr && ctl.load), "beat taken during clearing pass")

endmodule

FILE: hdl/refcounted_page_allocator_core.sv
// top level of the reference-counted page allocator; uses rpa_pkg, rpa_ctrl, rpa_datapath
// one beat at a time: the count and stack memories are read, then execute writes them
// and loads the result register; execute stalls while the result register is full
// reset clears control at once, then sweeps all NUM_PAGES count memory entries
// (32768 by default) with in_ready low; cfg writes are taken during the sweep
// first_usable_page resets to 0, free stack starts empty
module refcounted_page_allocator_core #(
    parameter int NUM_PAGES  = rpa_pkg::NUM_PAGES_DEF,
    parameter int COUNT_BITS = rpa_pkg::COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rpa_pkg::PAGE_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rpa_pkg::CMD_W-1:0]     cmd,
    input  logic [rpa_pkg::PAGE_W-1:0]    page_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rpa_pkg::PAGE_W-1:0]    page_index_res,
    output logic [rpa_pkg::REFC_W-1:0]    ref_count,
    output logic [rpa_pkg::STATUS_W-1:0]  status,
    output logic                          returned_to_pool
);

    rpa_pkg::ctrl_cmd_t  ctl;
    rpa_pkg::dp_status_t sts;

    assign cfg_ready = 1'b1;

    rpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl),
        .sts       (sts)
    );

    rpa_datapath #(
        .NUM_PAGES  (NUM_PAGES),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .sts              (sts),
        .cfg_valid        (cfg_valid),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .page_index       (page_index),
        .page_index_res   (page_index_res),
        .ref_count        (ref_count),
        .status           (status),
        .returned_to_pool (returned_to_pool)
    );

endmodule
